@@ rtl/mwio_pkg.sv @@
`timescale 1ns / 1ps
// Package for the weighted interval overlap block: fixed field widths,
// saturation limits and the beat struct handed along the slot chain.
// No dependencies.
package mwio_pkg;

    localparam int POS_W    = 32;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W  = 22;
    localparam int COUNT_W  = 7;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Interval fields as they travel from slot to slot
    typedef struct packed {
        logic                first_range;
        logic [POS_W-1:0]    range_start;
        logic [POS_W-1:0]    range_end;
        logic [WEIGHT_W-1:0] range_weight;
    } t_mwio_beat;

endpackage

@@ rtl/mwio_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for interval input and result output.
// Depends on mwio_pkg for field widths.
interface mwio_in_if;
    logic                          valid;
    logic                          ready;
    logic                          first_range;
    logic [mwio_pkg::POS_W-1:0]    range_start;
    logic [mwio_pkg::POS_W-1:0]    range_end;
    logic [mwio_pkg::WEIGHT_W-1:0] range_weight;

    modport source (output valid, first_range, range_start, range_end, range_weight,
                    input ready);
    modport sink (input valid, first_range, range_start, range_end, range_weight,
                  output ready);
endinterface

interface mwio_out_if;
    logic                         valid;
    logic                         ready;
    logic [mwio_pkg::TOTAL_W-1:0] live_total;
    logic [mwio_pkg::TOTAL_W-1:0] peak_total;
    logic [mwio_pkg::COUNT_W-1:0] active_count;
    logic                         store_overflow;

    modport source (output valid, live_total, peak_total, active_count, store_overflow,
                    input ready);
    modport sink (input valid, live_total, peak_total, active_count, store_overflow,
                  output ready);
endinterface

@@ rtl/mwio_cell.sv @@
`timescale 1ns / 1ps
// One slot of the interval store: expires its interval against a passing beat,
// claims the beat if still free, and forwards the beat with updated sums.
// Depends on mwio_pkg.
module mwio_cell #(
    parameter int TW = 22,
    parameter int CW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_vld,
    input  mwio_pkg::t_mwio_beat i_beat,
    input  logic                 i_placed,
    input  logic [TW-1:0]        i_removed,
    input  logic [CW-1:0]        i_count,
    output logic                 o_vld,
    output mwio_pkg::t_mwio_beat o_beat,
    output logic                 o_placed,
    output logic [TW-1:0]        o_removed,
    output logic [CW-1:0]        o_count
);

    logic                          r_valid;
    logic [mwio_pkg::POS_W-1:0]    r_end;
    logic [mwio_pkg::WEIGHT_W-1:0] r_weight;

    logic                 r_vld;
    mwio_pkg::t_mwio_beat r_beat;
    logic                 r_placed;
    logic [TW-1:0]        r_removed;
    logic [CW-1:0]        r_count;

    logic          w_keep;
    logic          w_expire;
    logic          w_stay;
    logic          w_take;
    logic          n_valid;
    logic          n_placed;
    logic [TW-1:0] n_removed;
    logic [CW-1:0] n_count;

    // Expire against the new start, then claim the slot if it is free
    always_comb begin
        w_keep    = r_valid && !i_beat.first_range;
        w_expire  = w_keep && (r_end < i_beat.range_start);
        w_stay    = w_keep && !w_expire;
        w_take    = i_vld && !i_placed && !w_stay;
        n_valid   = w_take || w_stay;
        n_placed  = i_placed || w_take;
        n_removed = w_expire ? i_removed + TW'(r_weight) : i_removed;
        n_count   = i_count + CW'(n_valid);
    end

    // Slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv && i_vld) begin
            r_valid <= n_valid;
        end
    end

    // Slot contents
    always_ff @(posedge i_clk) begin
        if (i_adv && w_take) begin
            r_end    <= i_beat.range_end;
            r_weight <= i_beat.range_weight;
        end
    end

    // Hand the beat to the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat    <= i_beat;
            r_placed  <= n_placed;
            r_removed <= n_removed;
            r_count   <= n_count;
        end
    end

    assign o_vld     = r_vld;
    assign o_beat    = r_beat;
    assign o_placed  = r_placed;
    assign o_removed = r_removed;
    assign o_count   = r_count;

endmodule

@@ rtl/mwio_tail.sv @@
`timescale 1ns / 1ps
// End of the slot chain: keeps live total, peak and overflow, and holds the
// result register for the output channel. Depends on mwio_pkg.
module mwio_tail #(
    parameter int TW = 22,
    parameter int CW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_vld,
    input  mwio_pkg::t_mwio_beat i_beat,
    input  logic                 i_placed,
    input  logic [TW-1:0]        i_removed,
    input  logic [CW-1:0]        i_count,
    output logic                 o_vld,
    output logic [mwio_pkg::TOTAL_W-1:0] o_live_total,
    output logic [mwio_pkg::TOTAL_W-1:0] o_peak_total,
    output logic [mwio_pkg::COUNT_W-1:0] o_active_count,
    output logic                 o_store_overflow
);

    localparam int STW = (TW > mwio_pkg::TOTAL_W) ? TW : mwio_pkg::TOTAL_W;
    localparam int SCW = (CW > mwio_pkg::COUNT_W) ? CW : mwio_pkg::COUNT_W;

    logic [TW-1:0] r_total;
    logic [TW-1:0] r_peak;
    logic          r_ovf;

    logic                         r_vld;
    logic [mwio_pkg::TOTAL_W-1:0] r_live_out;
    logic [mwio_pkg::TOTAL_W-1:0] r_peak_out;
    logic [mwio_pkg::COUNT_W-1:0] r_count_out;
    logic                         r_ovf_out;

    logic [TW-1:0]  w_base_total;
    logic [TW-1:0]  w_base_peak;
    logic [TW-1:0]  w_add;
    logic [TW-1:0]  n_total;
    logic [TW-1:0]  n_peak;
    logic           n_ovf;
    logic [STW-1:0] w_total_x;
    logic [STW-1:0] w_peak_x;
    logic [SCW-1:0] w_count_x;
    logic [mwio_pkg::TOTAL_W-1:0] n_live_out;
    logic [mwio_pkg::TOTAL_W-1:0] n_peak_out;
    logic [mwio_pkg::COUNT_W-1:0] n_count_out;

    // Fold in the expired weights and the new interval
    always_comb begin
        w_base_total = i_beat.first_range ? '0 : r_total;
        w_base_peak  = i_beat.first_range ? '0 : r_peak;
        w_add        = i_placed ? TW'(i_beat.range_weight) : '0;
        n_total      = w_base_total - i_removed + w_add;
        n_peak       = (n_total > w_base_peak) ? n_total : w_base_peak;
        n_ovf        = (!i_beat.first_range && r_ovf) || !i_placed;

        // Saturate to the field widths
        w_total_x    = STW'(n_total);
        w_peak_x     = STW'(n_peak);
        w_count_x    = SCW'(i_count);
        n_live_out   = (w_total_x > STW'(mwio_pkg::TOTAL_MAX)) ? mwio_pkg::TOTAL_MAX
                                                             : w_total_x[mwio_pkg::TOTAL_W-1:0];
        n_peak_out   = (w_peak_x > STW'(mwio_pkg::TOTAL_MAX)) ? mwio_pkg::TOTAL_MAX
                                                            : w_peak_x[mwio_pkg::TOTAL_W-1:0];
        n_count_out  = (w_count_x > SCW'(mwio_pkg::COUNT_MAX)) ? mwio_pkg::COUNT_MAX
                                                             : w_count_x[mwio_pkg::COUNT_W-1:0];
    end

    // Sweep totals and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_peak  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_adv && i_vld) begin
            r_total <= n_total;
            r_peak  <= n_peak;
            r_ovf   <= n_ovf;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_vld) begin
            r_live_out  <= n_live_out;
            r_peak_out  <= n_peak_out;
            r_count_out <= n_count_out;
            r_ovf_out   <= n_ovf;
        end
    end

    assign o_vld            = r_vld;
    assign o_live_total     = r_live_out;
    assign o_peak_total     = r_peak_out;
    assign o_active_count   = r_count_out;
    assign o_store_overflow = r_ovf_out;

endmodule

@@ rtl/max_weighted_interval_overlap.sv @@
`timescale 1ns / 1ps
// Maximum weighted interval overlap by line sweep.
// Input channel i_in carries one interval per beat: first_range, range_start,
// range_end (inclusive) and range_weight. Output channel o_out returns one
// beat per interval: live_total, peak_total, active_count, store_overflow.
// The store is a chain of CAPACITY slot cells. Each interval walks the chain
// one cell per cycle while o_out does not stall; at each cell it expires the
// held interval if that ends before the new start, and drops into the first
// free cell it meets. Each beat is registered in every cell, then in the
// result register; the chain takes a new interval every cycle unless stalled.
// The last stage folds the expired weights into the live total and peak.
// Reset empties every slot and clears totals and overflow; no clearing pass
// is needed. first_range does the same for one sweep, ahead of its interval.
// While a result waits on o_out, the whole chain holds and i_in.ready falls.
// Depends on mwio_pkg, mwio_if, mwio_cell and mwio_tail.
module max_weighted_interval_overlap #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwio_in_if.sink     i_in,
    mwio_out_if.source  o_out
);

    localparam int TW = $clog2(CAPACITY * (2 ** mwio_pkg::WEIGHT_W - 1) + 1);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                 w_adv;
    logic                 w_vld     [0:CAPACITY];
    mwio_pkg::t_mwio_beat w_beat    [0:CAPACITY];
    logic                 w_placed  [0:CAPACITY];
    logic [TW-1:0]        w_removed [0:CAPACITY];
    logic [CW-1:0]        w_count   [0:CAPACITY];

    // Advance the chain unless a result is stuck at the output
    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Feed the chain head
    assign w_vld[0]     = i_in.valid;
    assign w_beat[0]    = '{first_range:  i_in.first_range,
                            range_start:  i_in.range_start,
                            range_end:    i_in.range_end,
                            range_weight: i_in.range_weight};
    assign w_placed[0]  = 1'b0;
    assign w_removed[0] = '0;
    assign w_count[0]   = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        mwio_cell #(
            .TW (TW),
            .CW (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_vld     (w_vld[g]),
            .i_beat    (w_beat[g]),
            .i_placed  (w_placed[g]),
            .i_removed (w_removed[g]),
            .i_count   (w_count[g]),
            .o_vld     (w_vld[g+1]),
            .o_beat    (w_beat[g+1]),
            .o_placed  (w_placed[g+1]),
            .o_removed (w_removed[g+1]),
            .o_count   (w_count[g+1])
        );
    end

    mwio_tail #(
        .TW (TW),
        .CW (CW)
    ) u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (w_adv),
        .i_vld            (w_vld[CAPACITY]),
        .i_beat           (w_beat[CAPACITY]),
        .i_placed         (w_placed[CAPACITY]),
        .i_removed        (w_removed[CAPACITY]),
        .i_count          (w_count[CAPACITY]),
        .o_vld            (o_out.valid),
        .o_live_total     (o_out.live_total),
        .o_peak_total     (o_out.peak_total),
        .o_active_count   (o_out.active_count),
        .o_store_overflow (o_out.store_overflow)
    );

`ifndef SYNTHESIS
    // Peak never trails the live total
    a_peak_ge_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.peak_total >= o_out.live_total))
        else $error("peak_total below live_total");

    // A stalled result blocks new input beats
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // A result that is taken is replaced or cleared on the next edge
    a_out_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (o_out.valid == $past(w_vld[CAPACITY])))
        else $error("output register did not follow the chain");

    // Occupancy never exceeds the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (CW'(o_out.active_count) <= CW'(CAPACITY)
                         || o_out.active_count == mwio_pkg::COUNT_MAX))
        else $error("active_count beyond capacity");
`endif

endmodule

@@ sim/max_weighted_interval_overlap_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for max_weighted_interval_overlap: a short table of
// intervals, then random sweeps, each result checked against a local sweep model or a fixed row's hand-written result.
// Depends on mwio_pkg, mwio_if and the block itself.
module max_weighted_interval_overlap_tb;

    localparam int DUT_CAP        = 64;
    localparam int PIPE_LAT       = DUT_CAP + 1;
    localparam int RAND_ITEMS     = 800;
    localparam int PHASE_LEN      = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum {
        SWEEP_SPARSE,
        SWEEP_DENSE,
        SWEEP_NOISE,
        SWEEP_BROKEN
    } t_sweep_kind;

    typedef struct packed {
        logic [mwio_pkg::TOTAL_W-1:0] live_total;
        logic [mwio_pkg::TOTAL_W-1:0] peak_total;
        logic [mwio_pkg::COUNT_W-1:0] active_count;
        logic                         store_overflow;
    } t_overlap_result;

    // One row of the directed table; fixed rows carry a hand-written result
    typedef struct packed {
        mwio_pkg::t_mwio_beat beat;
        logic                 fixed;
        t_overlap_result      res;
    } t_interval_row;

    logic i_clk;
    logic i_rst_n;

    mwio_in_if  intv_ch ();
    mwio_out_if res_ch ();

    max_weighted_interval_overlap #(
        .CAPACITY(DUT_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (intv_ch),
        .o_out  (res_ch)
    );

    // Local copy of the interval store and sweep totals
    logic [mwio_pkg::POS_W-1:0]    held_end    [DUT_CAP];
    logic [mwio_pkg::WEIGHT_W-1:0] held_weight [DUT_CAP];
    logic                          held_valid  [DUT_CAP];
    int unsigned                   sweep_total;
    int unsigned                   sweep_peak;
    logic                          sweep_ovf;

    t_overlap_result overlap_expect_q [$];
    t_interval_row   interval_table   [$];

    int src_gap_pct;
    int res_stall_pct;
    int err_cnt;
    int intervals_sent;
    int rand_items;
    int sweeps_run;
    int results_seen;
    int full_store_seen;
    int overflow_seen_n;
    int unsigned peak_max_seen;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance the sweep model by one interval and return its result
    function automatic t_overlap_result sweep_step(input mwio_pkg::t_mwio_beat b);
        int free_slot;
        int unsigned held_n;
        t_overlap_result r;
        if (b.first_range) begin
            foreach (held_valid[i]) held_valid[i] = 1'b0;
            sweep_total = 0;
            sweep_peak  = 0;
            sweep_ovf   = 1'b0;
        end
        // Expire intervals that ended before the new start
        foreach (held_valid[i]) begin
            if (held_valid[i] && held_end[i] < b.range_start) begin
                held_valid[i] = 1'b0;
                sweep_total  -= held_weight[i];
            end
        end
        free_slot = -1;
        held_n    = 0;
        foreach (held_valid[i]) begin
            if (held_valid[i])
                held_n++;
            else if (free_slot < 0)
                free_slot = i;
        end
        // Insert into the lowest free slot, or flag the drop
        if (free_slot >= 0) begin
            held_valid[free_slot]  = 1'b1;
            held_end[free_slot]    = b.range_end;
            held_weight[free_slot] = b.range_weight;
            sweep_total += b.range_weight;
            if (sweep_total > sweep_peak)
                sweep_peak = sweep_total;
            held_n++;
        end else begin
            sweep_ovf = 1'b1;
        end
        r.live_total     = (sweep_total > mwio_pkg::TOTAL_MAX) ? mwio_pkg::TOTAL_MAX
                                                               : sweep_total[mwio_pkg::TOTAL_W-1:0];
        r.peak_total     = (sweep_peak > mwio_pkg::TOTAL_MAX) ? mwio_pkg::TOTAL_MAX
                                                              : sweep_peak[mwio_pkg::TOTAL_W-1:0];
        r.active_count   = (held_n > mwio_pkg::COUNT_MAX) ? mwio_pkg::COUNT_MAX
                                                          : held_n[mwio_pkg::COUNT_W-1:0];
        r.store_overflow = sweep_ovf;
        return r;
    endfunction

    // Present one interval, hold it until accepted, then log its expected result
    task automatic send_interval(input mwio_pkg::t_mwio_beat b, input logic fixed,
                                 input t_overlap_result fixed_res);
        t_overlap_result pred;
        while (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            intv_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        intv_ch.valid        <= 1'b1;
        intv_ch.first_range  <= b.first_range;
        intv_ch.range_start  <= b.range_start;
        intv_ch.range_end    <= b.range_end;
        intv_ch.range_weight <= b.range_weight;
        @(posedge i_clk);
        while (!intv_ch.ready) @(posedge i_clk);
        pred = sweep_step(b);
        overlap_expect_q = {overlap_expect_q, (fixed ? fixed_res : pred)};
        intervals_sent++;
    endtask

    // Hold the input off until every outstanding result has come back
    task automatic drain_results();
        intv_ch.valid <= 1'b0;
        do @(posedge i_clk); while (overlap_expect_q.size() != 0);
    endtask

    task automatic add_row(input logic f, input logic [mwio_pkg::POS_W-1:0] s,
                           input logic [mwio_pkg::POS_W-1:0] e,
                           input logic [mwio_pkg::WEIGHT_W-1:0] w, input logic fixed,
                           input int live, input int peak, input int cnt, input logic ovf);
        t_interval_row row;
        row.beat.first_range     = f;
        row.beat.range_start     = s;
        row.beat.range_end       = e;
        row.beat.range_weight    = w;
        row.fixed                = fixed;
        row.res.live_total       = live[mwio_pkg::TOTAL_W-1:0];
        row.res.peak_total       = peak[mwio_pkg::TOTAL_W-1:0];
        row.res.active_count     = cnt[mwio_pkg::COUNT_W-1:0];
        row.res.store_overflow   = ovf;
        interval_table = {interval_table, row};
    endtask

    // Emit one random sweep of the given shape
    task automatic gen_sweep(input t_sweep_kind kind, input logic heavy);
        int n;
        int w_pick;
        logic [mwio_pkg::POS_W-1:0] pos;
        mwio_pkg::t_mwio_beat b;
        t_overlap_result none;
        none = '0;
        pos  = $urandom;
        case (kind)
            SWEEP_SPARSE: n = $urandom_range(4, 30);
            SWEEP_DENSE:  n = $urandom_range(66, 90);
            SWEEP_NOISE:  n = $urandom_range(1, 8);
            default:      n = $urandom_range(4, 20);
        endcase
        for (int k = 0; k < n; k++) begin
            w_pick = $urandom_range(0, 7);
            b.first_range  = (k == 0) && (kind == SWEEP_SPARSE || kind == SWEEP_DENSE);
            b.range_weight = (heavy || w_pick == 1) ? 16'hFFFF :
                             (w_pick == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
            case (kind)
                SWEEP_SPARSE: begin
                    pos          += $urandom_range(0, 64);
                    b.range_start = pos;
                    b.range_end   = pos + $urandom_range(0, 200);
                end
                SWEEP_DENSE: begin
                    // Long intervals packed together: the store fills and overflows
                    pos          += $urandom_range(0, 3);
                    b.range_start = pos;
                    b.range_end   = pos + $urandom_range(1000, 100000);
                end
                SWEEP_NOISE: begin
                    b.first_range = ($urandom_range(0, 7) == 0);
                    b.range_start = $urandom;
                    b.range_end   = $urandom;
                end
                default: begin
                    // No fresh start, starts wander back and forth, ends may precede starts
                    pos          += $urandom_range(0, 200) - 100;
                    b.range_start = pos;
                    b.range_end   = pos + $urandom_range(0, 300) - 50;
                end
            endcase
            send_interval(b, 1'b0, none);
        end
        rand_items += n;
        sweeps_run++;
    endtask

    // Result sink: random back-pressure and field-by-field comparison
    initial begin
        t_overlap_result exp_r;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (overlap_expect_q.size() == 0) begin
                    $error("result beat arrived with nothing expected");
                    err_cnt++;
                end else begin
                    exp_r = overlap_expect_q.pop_front();
                    if (res_ch.live_total !== exp_r.live_total) begin
                        $error("live_total: expected %0d, got %0d",
                               exp_r.live_total, res_ch.live_total);
                        err_cnt++;
                    end
                    if (res_ch.peak_total !== exp_r.peak_total) begin
                        $error("peak_total: expected %0d, got %0d",
                               exp_r.peak_total, res_ch.peak_total);
                        err_cnt++;
                    end
                    if (res_ch.active_count !== exp_r.active_count) begin
                        $error("active_count: expected %0d, got %0d",
                               exp_r.active_count, res_ch.active_count);
                        err_cnt++;
                    end
                    if (res_ch.store_overflow !== exp_r.store_overflow) begin
                        $error("store_overflow: expected %0d, got %0d",
                               exp_r.store_overflow, res_ch.store_overflow);
                        err_cnt++;
                    end
                    if (exp_r.active_count == DUT_CAP)
                        full_store_seen++;
                    if (exp_r.store_overflow)
                        overflow_seen_n++;
                    if (exp_r.peak_total > peak_max_seen)
                        peak_max_seen = exp_r.peak_total;
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
        end
    end

    // Watchdog: give up after a long run of cycles with no beat on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((intv_ch.valid && intv_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, overlap_expect_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial begin
        t_interval_row row;
        int phase;
        int last_phase;
        int pick;

        i_rst_n              <= 1'b0;
        intv_ch.valid        <= 1'b0;
        intv_ch.first_range  <= 1'b0;
        intv_ch.range_start  <= '0;
        intv_ch.range_end    <= '0;
        intv_ch.range_weight <= '0;
        src_gap_pct     = 0;
        res_stall_pct   = 0;
        err_cnt         = 0;
        intervals_sent  = 0;
        rand_items      = 0;
        sweeps_run      = 0;
        results_seen    = 0;
        full_store_seen = 0;
        overflow_seen_n = 0;
        peak_max_seen   = 0;
        foreach (held_valid[i]) held_valid[i] = 1'b0;
        sweep_total = 0;
        sweep_peak  = 0;
        sweep_ovf   = 1'b0;

        // Directed intervals: first item straight after reset without a fresh
        // start, field extremes, end before start, zero length, sweep restarts
        add_row(1'b0, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 0, 0, 1, 1'b0);
        add_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 65535, 65535, 1, 1'b0);
        add_row(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b1, 131070, 131070, 2, 1'b0);
        add_row(1'b0, 32'h0000_0000, 32'h0000_0005, 16'h0003, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b0, 32'h0000_0001, 32'h0000_0001, 16'h0007, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b0, 32'h0000_0006, 32'h0000_0006, 16'h0000, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b0, 32'h0000_0007, 32'h0000_0010, 16'h8000, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b1, 32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1, 0, 0, 1, 1'b0);
        add_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5555, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 1'b0, 0, 0, 0, 1'b0);
        add_row(1'b1, 32'h0000_0003, 32'h0000_0002, 16'hFFFF, 1'b1, 65535, 65535, 1, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (interval_table[i]) begin
            row = interval_table[i];
            send_interval(row.beat, row.fixed, row.res);
        end
        drain_results();

        // Fill the store with heaviest weights first: totals and count at their top
        gen_sweep(SWEEP_DENSE, 1'b1);

        // Random sweeps, cycling through idle/stall phases with a drain at each switch
        last_phase = 0;
        while (rand_items < RAND_ITEMS) begin
            phase = (rand_items / PHASE_LEN) % 4;
            if (phase != last_phase) begin
                drain_results();
                case (phase)
                    1:       begin src_gap_pct = 58; res_stall_pct = 0;  end
                    2:       begin src_gap_pct = 0;  res_stall_pct = 58; end
                    3:       begin src_gap_pct = 6;  res_stall_pct = 6;  end
                    default: begin src_gap_pct = 0;  res_stall_pct = 0;  end
                endcase
                last_phase = phase;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
                gen_sweep(SWEEP_SPARSE, 1'b0);
            else if (pick == 6)
                gen_sweep(SWEEP_DENSE, ($urandom_range(0, 3) == 0));
            else if (pick < 9)
                gen_sweep(SWEEP_NOISE, 1'b0);
            else
                gen_sweep(SWEEP_BROKEN, 1'b0);
        end

        // Wind down: wait for the last results, then watch for strays
        intv_ch.valid <= 1'b0;
        while (overlap_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        if (overlap_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", overlap_expect_q.size());
            err_cnt++;
        end

        $display("Sent %0d intervals (%0d random sweeps), checked %0d results.",
                 intervals_sent, sweeps_run, results_seen);
        $display("Store full in %0d results, overflow flagged in %0d, highest peak %0d.",
                 full_store_seen, overflow_seen_n, peak_max_seen);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mwio_pkg.sv
rtl/mwio_if.sv
rtl/mwio_cell.sv
rtl/mwio_tail.sv
rtl/max_weighted_interval_overlap.sv
sim/max_weighted_interval_overlap_tb.sv
